// ----- hdl/dbnc_pkg.sv -----
// dbnc_pkg: shared types and constants for the multichannel input debouncer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dbnc_pkg;

    // configuration port geometry
    localparam int DEBOUNCE_W = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_MODE   = 8'd1;

    // register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TIME_RST = 16'd20;
    localparam logic                  MANUAL_MODE_RST   = 1'b1;

    // per-transaction control broadcast to every lane
    typedef struct packed {
        logic accept;
        logic seed;
        logic manual;
    } t_lane_ctl;

    // what one lane found for the current transaction
    typedef struct packed {
        logic stable;
        logic toggle;
    } t_lane_res;

endpackage

// ----- hdl/dbnc_lane.sv -----
// dbnc_lane: one debounce channel, holding its last raw bit, stable bit and change time
// depends on dbnc_pkg
`timescale 1ns / 1ps

module dbnc_lane #(
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dbnc_pkg::t_lane_ctl            i_ctl,
    input  logic [dbnc_pkg::DEBOUNCE_W-1:0] i_debounce_time,
    input  logic                           i_raw,
    input  logic [TIME_BITS-1:0]           i_now,
    output dbnc_pkg::t_lane_res            o_res
);
    import dbnc_pkg::*;

    logic                 r_prev;
    logic                 r_deb;
    logic [TIME_BITS-1:0] r_change_time;

    logic                 n_prev;
    logic                 n_deb;
    logic [TIME_BITS-1:0] n_change_time;

    logic                 w_chg;
    logic [TIME_BITS-1:0] w_ct;
    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_take;

    // change time seen by this transaction, then the elapsed-time check
    always_comb begin
        w_chg     = i_raw != r_prev;
        w_ct      = w_chg ? i_now : r_change_time;
        w_elapsed = i_now - w_ct;
        w_take    = (i_raw != r_deb) && (w_elapsed >= TIME_BITS'(i_debounce_time));
    end

    // next state: seeding copies the sample, otherwise debounce
    always_comb begin
        n_prev        = i_raw;
        n_change_time = i_ctl.seed ? i_now : w_ct;
        if (i_ctl.seed) begin
            n_deb = i_raw;
        end else begin
            n_deb = w_take ? i_raw : r_deb;
        end
    end

    assign o_res.stable = n_deb;
    assign o_res.toggle = i_ctl.accept && !i_ctl.seed && w_take && i_raw && i_ctl.manual;

    // lane control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 1'b0;
            r_deb  <= 1'b0;
        end else if (i_ctl.accept) begin
            r_prev <= n_prev;
            r_deb  <= n_deb;
        end
    end

    // change time holds no reset: the seeding transaction writes it first
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_change_time <= n_change_time;
        end
    end

    // a toggle only ever comes with a newly high stable bit
    a_toggle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.toggle |-> (o_res.stable && !r_deb))
        else $error("toggle without rising stable bit");

    // seeding never requests a toggle
    a_seed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && i_ctl.seed) |-> !o_res.toggle)
        else $error("toggle on seeding transaction");

    // a raw edge records the current tick
    a_edge_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && (i_raw != r_prev)) |=> (r_change_time == $past(i_now)))
        else $error("change time not recorded on raw edge");

endmodule

// ----- hdl/dbnc_merge.sv -----
// dbnc_merge: gathers the lane results into output masks behind an output register and skid stage
// depends on dbnc_pkg
`timescale 1ns / 1ps

module dbnc_merge #(
    parameter int CHANNELS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  dbnc_pkg::t_lane_res i_lane [CHANNELS],
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_in_stall,
    output logic [CHANNELS-1:0] o_stable_inputs,
    output logic [CHANNELS-1:0] o_toggle_request
);
    import dbnc_pkg::*;

    logic [CHANNELS-1:0] w_stable;
    logic [CHANNELS-1:0] w_toggle;
    logic                w_out_fire;

    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_stable;
    logic [CHANNELS-1:0] r_out_toggle;
    logic                r_skid_valid;
    logic [CHANNELS-1:0] r_skid_stable;
    logic [CHANNELS-1:0] r_skid_toggle;

    // pack lane findings into masks
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            w_stable[ch] = i_lane[ch].stable;
            w_toggle[ch] = i_lane[ch].toggle;
        end
    end

    assign w_out_fire = r_out_valid && !i_stall;

    // output register valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_stable <= r_skid_stable;
                r_out_toggle <= r_skid_toggle;
            end else if (i_accept) begin
                r_out_stable <= w_stable;
                r_out_toggle <= w_toggle;
            end
        end else if (i_accept) begin
            r_skid_stable <= w_stable;
            r_skid_toggle <= w_toggle;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_in_stall       = r_skid_valid;
    assign o_stable_inputs  = r_out_stable;
    assign o_toggle_request = r_out_toggle;

    // the skid stage only ever holds data behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with empty output register");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall && i_accept))
        else $error("skid loaded without output stall");

    // output drains when nothing new arrives
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !r_skid_valid && !i_accept) |=> !r_out_valid)
        else $error("stale transaction left in output register");

endmodule

// ----- hdl/multichannel_input_debouncer_top.sv -----
// multichannel_input_debouncer_top: per-channel debounce lanes, merge stage and configuration registers
// depends on dbnc_pkg, dbnc_lane and dbnc_merge
// an accepted transaction's result is registered in the output register (in the skid stage if the output is stalled)
// throughput: one transaction per cycle while o_stall is low; all channels are evaluated in parallel lanes
// o_stall rises only while the skid stage holds a result behind a stalled output
// reset (synchronous, active low) clears seeding, lane levels and registers to defaults
`timescale 1ns / 1ps

module multichannel_input_debouncer_top #(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [CHANNELS-1:0]            i_raw_inputs,
    input  logic [TIME_BITS-1:0]           i_time_now,
    // output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [CHANNELS-1:0]            o_stable_inputs,
    output logic [CHANNELS-1:0]            o_toggle_request,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dbnc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dbnc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dbnc_pkg::*;

    logic                  r_seeded;
    logic [DEBOUNCE_W-1:0] r_debounce_time;
    logic                  r_manual_mode;

    logic                  w_accept;
    t_lane_ctl             w_ctl;
    t_lane_res             w_lane [CHANNELS];

    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign w_ctl.accept = w_accept;
    assign w_ctl.seed   = !r_seeded;
    assign w_ctl.manual = r_manual_mode;

    // first transaction seeds the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (w_accept) begin
            r_seeded <= 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_time <= DEBOUNCE_TIME_RST;
            r_manual_mode   <= MANUAL_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TIME: r_debounce_time <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_MANUAL_MODE:   r_manual_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // one lane per channel
    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        dbnc_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_debounce_time (r_debounce_time),
            .i_raw           (i_raw_inputs[g]),
            .i_now           (i_time_now),
            .o_res           (w_lane[g])
        );
    end

    // merge lane results into the output transaction
    dbnc_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_lane           (w_lane),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_in_stall       (o_stall),
        .o_stable_inputs  (o_stable_inputs),
        .o_toggle_request (o_toggle_request)
    );

endmodule
